[hdl/ije_pkg.sv]
package ije_pkg;

    localparam int TS_W       = 48;
    localparam int GAP_W      = 20;
    localparam int STALE_W    = 24;
    localparam int JIT_W      = 24;
    localparam int MS_W       = 14;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    localparam logic [GAP_W-1:0]   MIN_GAP_RESET = GAP_W'(4000);
    localparam logic [GAP_W-1:0]   MAX_GAP_RESET = GAP_W'(1000000);
    localparam logic [STALE_W-1:0] STALE_RESET   = STALE_W'(2000000);

    // Rounding to milliseconds: (S + 8000) / 16000, with S = 16 * jitter in us.
    // The divide is split into a shift by 7 and a reciprocal multiply for 125.
    localparam logic [JIT_W:0]  ROUND_BIAS = (JIT_W+1)'(8000);
    localparam int              DIV_SHIFT  = 7;
    localparam int              QUOT_W     = JIT_W + 1 - DIV_SHIFT;
    localparam int              RECIP_K    = 25;
    localparam int              RECIP_W    = 19;
    localparam logic [RECIP_W-1:0] RECIP_125 = RECIP_W'(268436);
    localparam int              PROD_W     = QUOT_W + RECIP_W;
    localparam int              MS_RAW_W   = PROD_W - RECIP_K;
    localparam logic [MS_W-1:0] JIT_MAX_MS = MS_W'(9999);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_GAP = 2'd0,
        CFG_MAX_GAP = 2'd1,
        CFG_STALE   = 2'd2
    } cfg_reg_t;

    typedef enum logic {
        REQ_ARRIVAL = 1'b0,
        REQ_QUERY   = 1'b1
    } req_t;

    typedef struct packed {
        logic [GAP_W-1:0]   min_gap;
        logic [GAP_W-1:0]   max_gap;
        logic [STALE_W-1:0] stale;
    } cfg_t;

    typedef struct packed {
        logic             active;
        logic [JIT_W-1:0] jitter;
    } report_t;

endpackage

[hdl/ije_track.sv]
module ije_track (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          step,
    input  ije_pkg::req_t                 req_type,
    input  logic [ije_pkg::TS_W-1:0]      timestamp_us,
    input  logic                          link_up,
    input  ije_pkg::cfg_t                 cfg,
    output ije_pkg::report_t              report
);

    logic [ije_pkg::TS_W-1:0]  last_batch_time_reg, last_batch_time_next;
    logic                      have_batch_reg, have_batch_next;
    logic [ije_pkg::GAP_W-1:0] prev_interval_reg, prev_interval_next;
    logic                      interval_valid_reg, interval_valid_next;
    logic [ije_pkg::JIT_W-1:0] jitter_scaled_reg, jitter_scaled_next;

    logic [ije_pkg::TS_W-1:0]  dt;
    logic [ije_pkg::GAP_W-1:0] gap;
    logic [ije_pkg::GAP_W-1:0] delta;
    logic [ije_pkg::JIT_W:0]   filt_sum;
    logic                      below_min;
    logic                      above_max;
    logic                      moved;
    logic                      fresh;

    // One subtract serves both the gap test and the age test of the report.
    assign dt        = timestamp_us - last_batch_time_reg;
    assign gap       = dt[ije_pkg::GAP_W-1:0];
    assign below_min = dt < ije_pkg::TS_W'(cfg.min_gap);
    assign above_max = dt > ije_pkg::TS_W'(cfg.max_gap);
    assign delta     = (gap >= prev_interval_reg) ? gap - prev_interval_reg
                                                  : prev_interval_reg - gap;
    assign filt_sum  = {1'b0, jitter_scaled_reg} - (ije_pkg::JIT_W+1)'(jitter_scaled_reg >> 4)
                     + (ije_pkg::JIT_W+1)'(delta);

    always_comb begin
        last_batch_time_next = last_batch_time_reg;
        have_batch_next      = have_batch_reg;
        prev_interval_next   = prev_interval_reg;
        interval_valid_next  = interval_valid_reg;
        jitter_scaled_next   = jitter_scaled_reg;
        moved                = 1'b0;
        if (req_type == ije_pkg::REQ_ARRIVAL) begin
            if (!have_batch_reg) begin
                last_batch_time_next = timestamp_us;
                have_batch_next      = 1'b1;
                moved                = 1'b1;
            end else if (!below_min) begin
                last_batch_time_next = timestamp_us;
                moved                = 1'b1;
                if (above_max) begin
                    interval_valid_next = 1'b0;
                end else begin
                    if (interval_valid_reg && prev_interval_reg != '0) begin
                        jitter_scaled_next = filt_sum[ije_pkg::JIT_W] ? '1
                                           : filt_sum[ije_pkg::JIT_W-1:0];
                    end
                    prev_interval_next  = gap;
                    interval_valid_next = 1'b1;
                end
            end
        end
        // A batch that just moved has age zero.
        fresh         = moved ? (cfg.stale != '0) : (dt < ije_pkg::TS_W'(cfg.stale));
        report.active = link_up && have_batch_next && fresh;
        report.jitter = jitter_scaled_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_batch_time_reg <= '0;
            have_batch_reg      <= 1'b0;
            prev_interval_reg   <= '0;
            interval_valid_reg  <= 1'b0;
            jitter_scaled_reg   <= '0;
        end else if (step) begin
            last_batch_time_reg <= last_batch_time_next;
            have_batch_reg      <= have_batch_next;
            prev_interval_reg   <= prev_interval_next;
            interval_valid_reg  <= interval_valid_next;
            jitter_scaled_reg   <= jitter_scaled_next;
        end
    end

    // An interval can only exist once a baseline has been recorded.
    assert property (@(posedge aclk) interval_valid_reg |-> have_batch_reg)
        else $error("interval marked valid without a batch baseline");

endmodule

[hdl/interarrival_jitter_estimator.sv]
// Interarrival jitter estimator.
// Input channel (s_valid/s_ready): one word per event, carrying the request
// type (packet arrival or display query), a 48-bit microsecond timestamp and
// the link state. Output channel (m_valid/m_ready): one word per input word,
// in order, carrying the current jitter in milliseconds (0 to 9999).
// Configuration channel (cfg_valid/cfg_ready): writes min gap, max gap and
// stale time by register index; it is always ready and is meant to be used
// while the block is idle.
// The word is caught in an input register at the accepting edge, then a stage
// applies the state update (baseline, interval and jitter filter) and samples
// the report, and a stage converts to milliseconds through a reciprocal
// multiply into the output register, which drives m_valid.
// Throughput is one word per cycle while the receiver keeps up; the state
// update completes in the cycle that moves a word out of the input register,
// so back to back arrivals need no bubbles.
// When the receiver stalls, words collect in the three stages and s_ready
// drops only once all of them are full. Reset (aresetn, synchronous, active
// low) empties the pipeline, clears the jitter state and loads the default
// configuration; no clearing pass is needed, so words are taken right away.
module interarrival_jitter_estimator (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_req_type,
    input  logic [ije_pkg::TS_W-1:0]          s_timestamp_us,
    input  logic                              s_link_up,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [ije_pkg::MS_W-1:0]          m_jitter_ms,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [ije_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ije_pkg::CFG_DATA_W-1:0]    cfg_data
);

    // Configuration registers.
    ije_pkg::cfg_t cfg_reg;

    // Stage 0: input register.
    logic                      v0_reg;
    ije_pkg::req_t             req_reg;
    logic [ije_pkg::TS_W-1:0]  ts_reg;
    logic                      link_reg;

    // Stage 1: sampled report after the state update.
    logic                      v1_reg;
    ije_pkg::report_t          rep1_reg;
    ije_pkg::report_t          rep_next;

    // Stage 2: output register.
    logic                      m_valid_reg;
    logic [ije_pkg::MS_W-1:0]  m_jitter_ms_reg, m_jitter_ms_next;

    logic out_free;
    logic st1_free;
    logic st0_free;
    logic adv0;
    logic adv1;

    logic [ije_pkg::JIT_W:0]      biased;
    logic [ije_pkg::QUOT_W-1:0]   div128;
    logic [ije_pkg::PROD_W-1:0]   prod;
    logic [ije_pkg::MS_RAW_W-1:0] ms_raw;

    // Each stage moves on when the one after it is empty or emptying.
    assign out_free = !m_valid_reg || m_ready;
    assign st1_free = !v1_reg || out_free;
    assign st0_free = !v0_reg || st1_free;
    assign adv0     = v0_reg && st1_free;
    assign adv1     = v1_reg && out_free;

    assign s_ready     = st0_free;
    assign cfg_ready   = 1'b1;
    assign m_valid     = m_valid_reg;
    assign m_jitter_ms = m_jitter_ms_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.min_gap <= ije_pkg::MIN_GAP_RESET;
            cfg_reg.max_gap <= ije_pkg::MAX_GAP_RESET;
            cfg_reg.stale   <= ije_pkg::STALE_RESET;
        end else if (cfg_valid) begin
            case (ije_pkg::cfg_reg_t'(cfg_index))
                ije_pkg::CFG_MIN_GAP: cfg_reg.min_gap <= cfg_data[ije_pkg::GAP_W-1:0];
                ije_pkg::CFG_MAX_GAP: cfg_reg.max_gap <= cfg_data[ije_pkg::GAP_W-1:0];
                ije_pkg::CFG_STALE:   cfg_reg.stale   <= cfg_data[ije_pkg::STALE_W-1:0];
                default: ;
            endcase
        end
    end

    // The tracker commits its state update in the cycle the word leaves stage 0,
    // so the next word always sees the state left by the one before it.
    ije_track u_track (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .step         (adv0),
        .req_type     (req_reg),
        .timestamp_us (ts_reg),
        .link_up      (link_reg),
        .cfg          (cfg_reg),
        .report       (rep_next)
    );

    // Milliseconds: floor((S + 8000) / 16000) = floor(floor((S + 8000) / 128) / 125),
    // and the divide by 125 is an exact reciprocal multiply over this range.
    assign biased = {1'b0, rep1_reg.jitter} + ije_pkg::ROUND_BIAS;
    assign div128 = biased[ije_pkg::JIT_W:ije_pkg::DIV_SHIFT];
    assign prod   = ije_pkg::PROD_W'(div128) * ije_pkg::PROD_W'(ije_pkg::RECIP_125);
    assign ms_raw = prod[ije_pkg::PROD_W-1:ije_pkg::RECIP_K];

    always_comb begin
        if (!rep1_reg.active) begin
            m_jitter_ms_next = '0;
        end else if (ije_pkg::MS_W'(ms_raw) > ije_pkg::JIT_MAX_MS) begin
            m_jitter_ms_next = ije_pkg::JIT_MAX_MS;
        end else begin
            m_jitter_ms_next = ije_pkg::MS_W'(ms_raw);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg      <= 1'b0;
            v1_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (st0_free) begin
                v0_reg <= s_valid;
            end
            if (st1_free) begin
                v1_reg <= v0_reg;
            end
            if (out_free) begin
                m_valid_reg <= v1_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (st0_free && s_valid) begin
            req_reg  <= ije_pkg::req_t'(s_req_type);
            ts_reg   <= s_timestamp_us;
            link_reg <= s_link_up;
        end
        if (adv0) begin
            rep1_reg <= rep_next;
        end
        if (adv1) begin
            m_jitter_ms_reg <= m_jitter_ms_next;
        end
    end

    // Input backpressure only when every stage holds a word and the sink stalls.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (v0_reg && v1_reg && m_valid_reg && !m_ready))
        else $error("input stalled while the pipeline had room");

    // A word leaving stage 0 always lands in stage 1.
    assert property (@(posedge aclk) disable iff (!aresetn)
        adv0 |=> v1_reg)
        else $error("word lost between stage 0 and stage 1");

    // An inactive report (no link, no batch or stale) must come out as zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (adv1 && !rep1_reg.active) |=> (m_jitter_ms_reg == '0))
        else $error("inactive report produced nonzero jitter");

    // The delivered value never exceeds the clamp.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_jitter_ms_reg <= ije_pkg::JIT_MAX_MS))
        else $error("jitter output above clamp");

endmodule

[tb/interarrival_jitter_estimator_tb.sv]
`timescale 1ns / 1ps

// Self-checking bench for the interarrival jitter estimator. Every input word
// (packet arrival or display query) is fed to a software copy of the jitter
// filter. The returned millisecond figure is queued and compared, in order,
// with each output word. Register settings change only while the block is
// empty, and both handshake sides idle at random to shake the pipeline.
module interarrival_jitter_estimator_tb;

    localparam int HALF_PERIOD  = 4;
    localparam int RESET_CYCLES = 6;
    // The long receiver stall must outlast the three pipeline stages by far.
    localparam int HOLD_CYCLES  = 120;
    // No handshake for this many cycles means the block has hung.
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 8;

    // Jitter is kept as 16 times the value in microseconds. Rounding to
    // milliseconds adds half of 16000 before the divide.
    localparam int unsigned HALF_MS_X16 = 8000;
    localparam int unsigned MS_X16      = 16000;
    localparam int unsigned MS_CEILING  = 9999;

    localparam logic [ije_pkg::TS_W-1:0] TS_ALL_ONES = '1;

    // Software copy of the estimator. It holds its own registers and filter
    // state and keeps the expected millisecond values of words in flight.
    class jitter_predictor;
        logic [ije_pkg::GAP_W-1:0]   min_gap;
        logic [ije_pkg::GAP_W-1:0]   max_gap;
        logic [ije_pkg::STALE_W-1:0] stale;

        logic [ije_pkg::TS_W-1:0]    batch_ts;
        bit                          have_batch;
        logic [ije_pkg::GAP_W-1:0]   last_interval;
        bit                          interval_ok;
        logic [ije_pkg::JIT_W-1:0]   jitter_x16;

        logic [ije_pkg::MS_W-1:0]    expected_ms[$];
        int                          errors;
        int                          checked;
        int                          nonzero;

        function new();
            min_gap       = ije_pkg::MIN_GAP_RESET;
            max_gap       = ije_pkg::MAX_GAP_RESET;
            stale         = ije_pkg::STALE_RESET;
            batch_ts      = '0;
            have_batch    = 1'b0;
            last_interval = '0;
            interval_ok   = 1'b0;
            jitter_x16    = '0;
            errors        = 0;
            checked       = 0;
            nonzero       = 0;
        endfunction

        function void write_reg(ije_pkg::cfg_reg_t idx,
                                logic [ije_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                ije_pkg::CFG_MIN_GAP: min_gap = data[ije_pkg::GAP_W-1:0];
                ije_pkg::CFG_MAX_GAP: max_gap = data[ije_pkg::GAP_W-1:0];
                ije_pkg::CFG_STALE:   stale   = data[ije_pkg::STALE_W-1:0];
                default: ;
            endcase
        endfunction

        function void add_arrival(logic [ije_pkg::TS_W-1:0] ts);
            logic [ije_pkg::TS_W-1:0]  dt;
            logic [ije_pkg::GAP_W-1:0] gap;
            logic [ije_pkg::GAP_W-1:0] delta;
            logic [ije_pkg::JIT_W+1:0] sum;
            if (!have_batch) begin
                batch_ts   = ts;
                have_batch = 1'b1;
                return;
            end
            dt = ts - batch_ts;
            // Arrivals inside the minimum gap belong to the current batch.
            if (dt < min_gap)
                return;
            batch_ts = ts;
            // An overlong gap (time running backwards lands here too) only
            // restarts the interval chain.
            if (dt > max_gap) begin
                interval_ok = 1'b0;
                return;
            end
            gap = dt[ije_pkg::GAP_W-1:0];
            // A stored interval of zero is never used as a reference.
            if (interval_ok && last_interval != '0) begin
                delta = (gap >= last_interval) ? gap - last_interval : last_interval - gap;
                sum = {2'b00, jitter_x16} - {6'd0, jitter_x16[ije_pkg::JIT_W-1:4]}
                    + {6'd0, delta};
                jitter_x16 = (sum > {2'b00, {ije_pkg::JIT_W{1'b1}}}) ? {ije_pkg::JIT_W{1'b1}}
                                                                     : sum[ije_pkg::JIT_W-1:0];
            end
            last_interval = gap;
            interval_ok   = 1'b1;
        endfunction

        function logic [ije_pkg::MS_W-1:0] jitter_in_ms(logic [ije_pkg::TS_W-1:0] ts,
                                                        logic link);
            logic [ije_pkg::TS_W-1:0] age;
            int unsigned              ms;
            if (!link || !have_batch)
                return '0;
            age = ts - batch_ts;
            if (age >= stale)
                return '0;
            ms = (int'(jitter_x16) + HALF_MS_X16) / MS_X16;
            if (ms > MS_CEILING)
                ms = MS_CEILING;
            return ms[ije_pkg::MS_W-1:0];
        endfunction

        // Called for each accepted input word; arrivals update the filter
        // before the answer is formed.
        function void note_word(ije_pkg::req_t kind, logic [ije_pkg::TS_W-1:0] ts,
                                logic link);
            if (kind == ije_pkg::REQ_ARRIVAL)
                add_arrival(ts);
            expected_ms.push_back(jitter_in_ms(ts, link));
        endfunction

        function void check_word(logic [ije_pkg::MS_W-1:0] got);
            logic [ije_pkg::MS_W-1:0] want;
            if (expected_ms.size() == 0) begin
                $error("jitter_ms: output word %0d arrived with nothing outstanding", got);
                errors++;
                return;
            end
            want = expected_ms.pop_front();
            checked++;
            if (got !== want) begin
                $error("jitter_ms mismatch: expected %0d, actual %0d", want, got);
                errors++;
            end
            if (got != '0)
                nonzero++;
        endfunction

        function int pending();
            return expected_ms.size();
        endfunction
    endclass

    logic                           aclk           = 1'b0;
    logic                           aresetn        = 1'b0;
    logic                           s_valid        = 1'b0;
    logic                           s_ready;
    logic                           s_req_type     = 1'b0;
    logic [ije_pkg::TS_W-1:0]       s_timestamp_us = '0;
    logic                           s_link_up      = 1'b0;
    logic                           m_valid;
    logic                           m_ready        = 1'b0;
    logic [ije_pkg::MS_W-1:0]       m_jitter_ms;
    logic                           cfg_valid      = 1'b0;
    logic                           cfg_ready;
    logic [ije_pkg::CFG_IDX_W-1:0]  cfg_index      = '0;
    logic [ije_pkg::CFG_DATA_W-1:0] cfg_data       = '0;

    jitter_predictor sb;

    // Idle chances in percent per word (sender) and per cycle (receiver).
    // In the closing phase quiet turns all idling off.
    int unsigned tx_idle_pct = 0;
    int unsigned rx_idle_pct = 0;
    bit          quiet       = 1'b0;
    bit          hold_req    = 1'b0;

    // The sender's running clock for random traffic.
    logic [ije_pkg::TS_W-1:0] cur_ts = '0;

    int n_arrivals = 0;
    int n_queries  = 0;
    int n_settings = 0;
    int long_holds = 0;
    int idle_cycles = 0;

    interarrival_jitter_estimator dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_req_type     (s_req_type),
        .s_timestamp_us (s_timestamp_us),
        .s_link_up      (s_link_up),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_jitter_ms    (m_jitter_ms),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always #HALF_PERIOD aclk = ~aclk;

    // Every output word taken at a rising edge is checked against the oldest
    // expected value.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_word(m_jitter_ms);
    end

    // Watchdog: any handshake on any channel restarts the count.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles + 1 >= STALL_LIMIT) begin
                $display("Watchdog: no handshake for %0d cycles, %0d words outstanding",
                         STALL_LIMIT, sb.pending());
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // Receiver. It drops ready in random bursts, or for one long stretch when
    // asked, so that words pile up in the pipeline and s_ready falls.
    initial begin
        int burst;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge aclk);
                hold_req = 1'b0;
                long_holds++;
            end else if (!quiet && rx_idle_pct != 0 && $urandom_range(0, 99) < rx_idle_pct) begin
                burst = $urandom_range(1, 17);
                m_ready <= 1'b0;
                repeat (burst - 1) @(negedge aclk);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Offers one word and returns once it has been taken. Valid stays high
    // afterwards so that the next call can follow back to back.
    task automatic send_word(ije_pkg::req_t kind, logic [ije_pkg::TS_W-1:0] stamp, logic link);
        int burst;
        if (!quiet && tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
            burst = $urandom_range(1, 17);
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (burst - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid        <= 1'b1;
        s_req_type     <= kind;
        s_timestamp_us <= stamp;
        s_link_up      <= link;
        do @(posedge aclk); while (!s_ready);
        sb.note_word(kind, stamp, link);
        if (kind == ije_pkg::REQ_ARRIVAL)
            n_arrivals++;
        else
            n_queries++;
    endtask

    task automatic release_input();
        @(negedge aclk);
        s_valid <= 1'b0;
    endtask

    // Waits until every expected output word has come back.
    task automatic drain();
        while (sb.pending() != 0)
            @(posedge aclk);
    endtask

    task automatic write_reg(ije_pkg::cfg_reg_t idx, logic [ije_pkg::CFG_DATA_W-1:0] data);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        sb.write_reg(idx, data);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Writes all three registers. The unused top bits of the gap registers
    // carry random junk, which the block must drop.
    task automatic set_regs(int unsigned min_us, int unsigned max_us, int unsigned stale_val);
        logic [ije_pkg::CFG_DATA_W-1:0] data;
        data = ije_pkg::CFG_DATA_W'($urandom);
        data[ije_pkg::GAP_W-1:0] = min_us[ije_pkg::GAP_W-1:0];
        write_reg(ije_pkg::CFG_MIN_GAP, data);
        data = ije_pkg::CFG_DATA_W'($urandom);
        data[ije_pkg::GAP_W-1:0] = max_us[ije_pkg::GAP_W-1:0];
        write_reg(ije_pkg::CFG_MAX_GAP, data);
        write_reg(ije_pkg::CFG_STALE, stale_val[ije_pkg::CFG_DATA_W-1:0]);
        n_settings++;
    endtask

    // Random traffic under the current registers. Most words are arrivals
    // whose gaps fall inside the window, either close to a nominal period
    // (small jitter) or spread across the window (large jitter). The rest are
    // same-batch arrivals, overlong gaps, clock steps backwards and queries at
    // random ages around the stale limit.
    task automatic run_random(int n_words, bit with_hold);
        longint   lo;
        longint   hi;
        longint   nominal;
        longint   gap;
        longint   spread;
        longint   age;
        int       pick;
        ije_pkg::req_t kind;
        logic     link;
        logic [ije_pkg::TS_W-1:0] stamp;
        lo = longint'(sb.min_gap);
        hi = longint'(sb.max_gap);
        nominal = (hi >= lo) ? lo + longint'($urandom_range(0, int'(hi - lo))) : 0;
        for (int i = 0; i < n_words; i++) begin
            pick = $urandom_range(0, 99);
            kind = ije_pkg::REQ_ARRIVAL;
            link = ($urandom_range(0, 9) != 0);
            if (pick < 55) begin
                if (hi < lo) begin
                    gap = longint'($urandom_range(0, (1 << ije_pkg::GAP_W) - 1));
                end else if (pick < 30) begin
                    spread = longint'($urandom_range(0, 4000));
                    gap = nominal + longint'($urandom_range(0, int'(2 * spread))) - spread;
                    if (gap < lo)
                        gap = lo;
                    if (gap > hi)
                        gap = hi;
                end else begin
                    gap = lo + longint'($urandom_range(0, int'(hi - lo)));
                end
                cur_ts = cur_ts + ije_pkg::TS_W'(gap);
                stamp = cur_ts;
            end else if (pick < 65) begin
                // Inside the current batch; the batch start does not move.
                gap = (lo == 0) ? 0 : longint'($urandom_range(0, int'(lo - 1)));
                stamp = cur_ts + ije_pkg::TS_W'(gap);
            end else if (pick < 72) begin
                gap = hi + 1 + longint'($urandom_range(0, 4000000));
                cur_ts = cur_ts + ije_pkg::TS_W'(gap);
                stamp = cur_ts;
            end else if (pick < 76) begin
                cur_ts = cur_ts - ije_pkg::TS_W'($urandom_range(1, 200000));
                stamp = cur_ts;
            end else begin
                kind = ije_pkg::REQ_QUERY;
                age = longint'($urandom_range(0, int'(sb.stale) + int'(sb.stale / 4) + 16));
                stamp = cur_ts + ije_pkg::TS_W'(age);
            end
            if (with_hold && i == n_words / 3)
                hold_req = 1'b1;
            send_word(kind, stamp, link);
        end
        release_input();
        drain();
    endtask

    initial begin
        logic [ije_pkg::TS_W-1:0] t;
        int unsigned              lo;
        int unsigned              hi;
        int unsigned              stale_val;

        sb = new();
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed words under the reset register values
        // (4000 us minimum, 1 s maximum, 2 s stale).
        tx_idle_pct = 30;
        rx_idle_pct = 10;
        send_word(ije_pkg::REQ_QUERY,   48'd0, 1'b1);         // nothing has arrived yet
        send_word(ije_pkg::REQ_ARRIVAL, 48'd0, 1'b1);         // first arrival sets the baseline
        send_word(ije_pkg::REQ_ARRIVAL, 48'd3999, 1'b1);      // one short of the minimum gap
        send_word(ije_pkg::REQ_ARRIVAL, 48'd4000, 1'b1);      // exactly the minimum gap
        send_word(ije_pkg::REQ_ARRIVAL, 48'd504000, 1'b1);    // first filter update
        send_word(ije_pkg::REQ_ARRIVAL, 48'd514000, 1'b0);    // arrival while the link is down
        send_word(ije_pkg::REQ_QUERY,   48'd2513999, 1'b1);   // last fresh microsecond
        send_word(ije_pkg::REQ_QUERY,   48'd2514000, 1'b1);   // exactly stale
        send_word(ije_pkg::REQ_ARRIVAL, 48'd1514000, 1'b1);   // gap equal to the maximum
        send_word(ije_pkg::REQ_ARRIVAL, 48'd2514001, 1'b1);   // one over the maximum
        send_word(ije_pkg::REQ_ARRIVAL, 48'd2534001, 1'b1);   // interval with no reference
        send_word(ije_pkg::REQ_ARRIVAL, 48'd2534000, 1'b1);   // clock steps backwards
        send_word(ije_pkg::REQ_ARRIVAL, TS_ALL_ONES, 1'b1);   // top of the timestamp range
        send_word(ije_pkg::REQ_ARRIVAL, 48'd49999, 1'b1);     // gap across the wrap point
        send_word(ije_pkg::REQ_ARRIVAL, 48'd109999, 1'b1);
        send_word(ije_pkg::REQ_QUERY,   TS_ALL_ONES, 1'b1);   // age wraps to a stale value
        send_word(ije_pkg::REQ_QUERY,   48'd109999, 1'b0);    // query with the link down
        send_word(ije_pkg::REQ_QUERY,   48'd110000, 1'b1);
        release_input();
        drain();

        // Widest window: no minimum gap, full maximum gap and stale time.
        // Two arrivals at one timestamp store a zero interval, which must
        // not act as a reference for the next one.
        set_regs(0, (1 << ije_pkg::GAP_W) - 1, (1 << ije_pkg::STALE_W) - 1);
        t = 48'h5555_5555_5555;
        send_word(ije_pkg::REQ_ARRIVAL, t, 1'b1);
        send_word(ije_pkg::REQ_ARRIVAL, t + 48'd100000, 1'b1);
        send_word(ije_pkg::REQ_ARRIVAL, t + 48'd100000, 1'b1);
        send_word(ije_pkg::REQ_ARRIVAL, t + 48'd300000, 1'b1);
        send_word(ije_pkg::REQ_ARRIVAL, t + 48'd1348575, 1'b1);  // interval at the full width
        send_word(ije_pkg::REQ_ARRIVAL, t + 48'd1348576, 1'b1);  // interval of one microsecond
        send_word(ije_pkg::REQ_QUERY,   t + 48'd1348576, 1'b1);
        cur_ts = t + 48'd1348576;
        run_random(100, 1'b0);

        // Inverted window and a zero stale time: every answer is zero.
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        set_regs((1 << ije_pkg::GAP_W) - 1, 0, 0);
        cur_ts = ije_pkg::TS_W'({$urandom, $urandom});
        run_random(60, 1'b0);

        // Random settings. Two of the phases include the long receiver stall
        // and one uses fully random register values.
        for (int p = 0; p < 4; p++) begin
            case ($urandom_range(0, 2))
                0: tx_idle_pct = 0;
                1: tx_idle_pct = 10;
                default: tx_idle_pct = 40;
            endcase
            rx_idle_pct = $urandom_range(0, 2) * 8;
            if (p == 1) begin
                lo = $urandom_range(0, (1 << ije_pkg::GAP_W) - 1);
                hi = $urandom_range(0, (1 << ije_pkg::GAP_W) - 1);
                stale_val = $urandom_range(0, (1 << ije_pkg::STALE_W) - 1);
            end else begin
                lo = $urandom_range(0, 60000);
                hi = lo + $urandom_range(0, (1 << ije_pkg::GAP_W) - 1 - lo);
                stale_val = $urandom_range(hi, (1 << ije_pkg::STALE_W) - 1);
            end
            set_regs(lo, hi, stale_val);
            cur_ts = ije_pkg::TS_W'({$urandom, $urandom});
            run_random(150, p == 0 || p == 2);
        end

        // Closing phase at the default values with no idling at all.
        quiet = 1'b1;
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        set_regs(4000, 1000000, 2000000);
        cur_ts = ije_pkg::TS_W'({$urandom, $urandom});
        run_random(150, 1'b0);

        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Checked %0d jitter words (%0d nonzero) from %0d arrivals and %0d queries.",
                 sb.checked, sb.nonzero, n_arrivals, n_queries);
        $display("Register settings used: %0d, window limits included; long output stalls: %0d.",
                 n_settings, long_holds);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("%0d mismatches, %0d words never answered", sb.errors, sb.pending());
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
